// File: rtl/ptp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ptp_pkg
// Shared widths, types and latencies for the point-to-triangle projection
// datapath. All widths follow from the coordinate width so the exact integer
// arithmetic never overflows.
// ============================================================================
package ptp_pkg;

    // Coordinate width of every input and output field. The fraction width
    // does not change any result bit, so it does not appear here.
    localparam int COORD_BITS = 32;

    // Difference of two coordinates.
    localparam int DIFF_W  = COORD_BITS + 1;
    // One product of two differences.
    localparam int PROD_W  = 2 * DIFF_W;
    // One component of a cross product of two difference vectors.
    localparam int CRS_W   = PROD_W + 1;
    // Dot product of a difference vector with a normal (signed).
    localparam int SC_W    = DIFF_W + CRS_W + 2;
    // Dot product of two cross-product vectors (signed).
    localparam int DOT_W   = 2 * CRS_W + 2;
    // Projection numerator: scale times one normal component (signed).
    localparam int NUM_W   = SC_W + CRS_W;
    // Rounding numerator 2*|num| + N.N (unsigned).
    localparam int XN_W    = NUM_W + 1;
    // Rounding divisor 2*N.N (unsigned).
    localparam int DEN_W   = DOT_W + 1;
    // Quotient width; the offset never exceeds the point-to-corner distance.
    localparam int QUO_W   = DIFF_W + 3;
    // Trial remainder width inside the divider.
    localparam int REM_W   = DEN_W + 1;

    // Chunked multiplier geometry: four chunks on A, two chunks on B.
    localparam int MUL_ACH = (SC_W + 3) / 4;
    localparam int MUL_BCH = (CRS_W + 1) / 2;
    localparam int MUL_A_W = 4 * MUL_ACH;
    localparam int MUL_B_W = 2 * MUL_BCH;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Register stages through the multiplier and the divider.
    localparam int MUL_LAT = 4;
    localparam int DIV_LAT = QUO_W + 1;

    // Three coordinate lanes.
    localparam int LANES   = 3;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // One finished result item.
    typedef struct packed {
        logic [LANES-1:0][COORD_BITS-1:0] proj;
        logic                             in_tri;
        logic                             degen;
    } t_result;

endpackage

// File: rtl/ptp_mul.sv
`timescale 1ns / 1ps
// ============================================================================
// ptp_mul
// Pipelined signed multiplier built from narrow chunk products. The partial
// products, the row sums, the pair sums and the final sum each get a register
// stage, and every stage advances only while i_en is high.
// ============================================================================
module ptp_mul
    import ptp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    localparam int PP_W = MUL_ACH + MUL_BCH + 2;

    logic signed [PP_W-1:0]    n_pp   [0:3][0:1];
    logic signed [PP_W-1:0]    r_pp   [0:3][0:1];
    logic signed [MUL_P_W-1:0] n_row  [0:3];
    logic signed [MUL_P_W-1:0] r_row  [0:3];
    logic signed [MUL_P_W-1:0] n_half [0:1];
    logic signed [MUL_P_W-1:0] r_half [0:1];
    logic signed [MUL_P_W-1:0] n_prod;
    logic signed [MUL_P_W-1:0] r_prod;

    // Chunk products. Only the top chunk of each operand carries the sign.
    always_comb begin
        logic signed [MUL_ACH:0] v_a;
        logic signed [MUL_BCH:0] v_b;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 2; j++) begin
                if (i == 3) begin
                    v_a = {i_a[MUL_A_W-1], i_a[i*MUL_ACH +: MUL_ACH]};
                end else begin
                    v_a = {1'b0, i_a[i*MUL_ACH +: MUL_ACH]};
                end
                if (j == 1) begin
                    v_b = {i_b[MUL_B_W-1], i_b[j*MUL_BCH +: MUL_BCH]};
                end else begin
                    v_b = {1'b0, i_b[j*MUL_BCH +: MUL_BCH]};
                end
                n_pp[i][j] = PP_W'(v_a) * PP_W'(v_b);
            end
        end
    end

    // Row sums over the two B chunks.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_row[i] = MUL_P_W'(r_pp[i][0]) + (MUL_P_W'(r_pp[i][1]) <<< MUL_BCH);
        end
    end

    // Pairs of rows, then the final sum.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_half[k] = r_row[2*k] + (r_row[2*k+1] <<< MUL_ACH);
        end
        n_prod = r_half[0] + (r_half[1] <<< (2 * MUL_ACH));
    end

    // Stage registers advance together with the surrounding pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp   <= n_pp;
            r_row  <= n_row;
            r_half <= n_half;
            r_prod <= n_prod;
        end
    end

    assign o_p = r_prod;

endmodule

// File: rtl/ptp_div.sv
`timescale 1ns / 1ps
// ============================================================================
// ptp_div
// Pipelined restoring divider for three lanes that share one divisor. Each
// stage after the entry stage resolves one quotient bit with one compare and
// subtract. The numerator is known to give a quotient below 2**QUO_W.
// ============================================================================
module ptp_div
    import ptp_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [DEN_W-1:0]                 i_den,
    input  logic [LANES-1:0][XN_W-1:0]       i_num,
    output logic [LANES-1:0][QUO_W-1:0]      o_quo
);

    logic [DEN_W-1:0]             r_den [0:QUO_W];
    logic [LANES-1:0][DEN_W-1:0]  r_rem [0:QUO_W];
    logic [LANES-1:0][QUO_W-1:0]  r_low [0:QUO_W];
    logic [LANES-1:0][QUO_W-1:0]  r_quo [0:QUO_W];
    logic [LANES-1:0][DEN_W-1:0]  n_rem [1:QUO_W];
    logic [LANES-1:0][QUO_W-1:0]  n_quo [1:QUO_W];

    // One quotient bit per stage: shift in the next numerator bit, then
    // subtract the divisor when it fits.
    always_comb begin
        logic [REM_W-1:0] v_trial;
        for (int s = 0; s < QUO_W; s++) begin
            for (int l = 0; l < LANES; l++) begin
                v_trial        = {r_rem[s][l], r_low[s][l][QUO_W-1-s]};
                n_quo[s+1][l]  = r_quo[s][l];
                if (v_trial >= {1'b0, r_den[s]}) begin
                    n_rem[s+1][l]              = DEN_W'(v_trial - {1'b0, r_den[s]});
                    n_quo[s+1][l][QUO_W-1-s]   = 1'b1;
                end else begin
                    n_rem[s+1][l]              = v_trial[DEN_W-1:0];
                end
            end
        end
    end

    // Entry stage loads the high numerator bits as the first remainder.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            for (int l = 0; l < LANES; l++) begin
                r_rem[0][l] <= DEN_W'(i_num[l][XN_W-1:QUO_W]);
                r_low[0][l] <= i_num[l][QUO_W-1:0];
                r_quo[0][l] <= '0;
            end
            for (int s = 1; s <= QUO_W; s++) begin
                r_den[s] <= r_den[s-1];
                r_low[s] <= r_low[s-1];
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];

endmodule

// File: rtl/point_triangle_projection.sv
`timescale 1ns / 1ps
// ============================================================================
// point_triangle_projection
// Projects a point onto the plane of a triangle along the edge cross product
// and tests the barycentric weights of the projection for the inside flag.
// ============================================================================
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  -------------------------
//  input    in         i_in_valid / o_in_stall    point, corners a, b, c
//  output   out        o_out_valid / i_out_stall  proj x/y/z, inside, degen
//
//  One transfer is accepted every cycle while o_in_stall is low; the longest
//  parts of the pipeline are the 36 quotient-bit stages of the rounding
//  divider and the two chunked multiplier passes.
//  Reset is synchronous and active low; it empties the pipeline and the
//  output stage. The pipeline freezes only while the skid register holds a
//  result, so one further result is taken while the output is stalled.
//
module point_triangle_projection
    import ptp_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic signed [COORD_BITS-1:0] i_corner_a_x,
    input  logic signed [COORD_BITS-1:0] i_corner_a_y,
    input  logic signed [COORD_BITS-1:0] i_corner_a_z,
    input  logic signed [COORD_BITS-1:0] i_corner_b_x,
    input  logic signed [COORD_BITS-1:0] i_corner_b_y,
    input  logic signed [COORD_BITS-1:0] i_corner_b_z,
    input  logic signed [COORD_BITS-1:0] i_corner_c_x,
    input  logic signed [COORD_BITS-1:0] i_corner_c_y,
    input  logic signed [COORD_BITS-1:0] i_corner_c_z,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_proj_x,
    output logic signed [COORD_BITS-1:0] o_proj_y,
    output logic signed [COORD_BITS-1:0] o_proj_z,
    output logic                         o_inside_res,
    output logic                         o_degenerate
);

    // Stage numbers of the pipeline registers.
    localparam int ST_DIF  = 1;
    localparam int ST_PRD  = ST_DIF + 1;
    localparam int ST_CRS  = ST_PRD + 1;
    localparam int ST_MUL1 = ST_CRS + MUL_LAT;
    localparam int ST_SUM  = ST_MUL1 + 1;
    localparam int ST_MUL2 = ST_SUM + MUL_LAT;
    localparam int ST_ABS  = ST_MUL2 + 1;
    localparam int ST_XN   = ST_ABS + 1;
    localparam int ST_DIVO = ST_XN + DIV_LAT;
    localparam int ST_FIN  = ST_DIVO + 1;

    localparam int PSUM_W  = QUO_W + 2;

    // Operand selection for the cross products a x b.
    localparam int IDX1 [0:2] = '{1, 2, 0};
    localparam int IDX2 [0:2] = '{2, 0, 1};

    localparam logic [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Control.
    logic               w_adv;
    logic               w_out_free;
    logic [ST_FIN:1]    r_vld;
    logic               r_out_vld;
    logic               r_skid_vld;

    // Input fields as lanes.
    t_coord             w_pt [0:2];
    t_coord             w_ca [0:2];
    t_coord             w_cb [0:2];
    t_coord             w_cc [0:2];

    // Differences: four cross products (normal and three sub-triangles).
    logic signed [DIFF_W-1:0] n_xa  [0:3][0:2];
    logic signed [DIFF_W-1:0] n_xb  [0:3][0:2];
    logic signed [DIFF_W-1:0] r_xa  [0:3][0:2];
    logic signed [DIFF_W-1:0] r_xb  [0:3][0:2];
    logic signed [DIFF_W-1:0] n_av  [0:2];
    logic signed [DIFF_W-1:0] r_av  [ST_DIF:ST_CRS][0:2];
    t_coord                   r_p   [ST_DIF:ST_DIVO][0:2];

    // Cross product terms and components.
    logic signed [PROD_W-1:0] n_xp  [0:3][0:5];
    logic signed [PROD_W-1:0] r_xp  [0:3][0:5];
    logic signed [CRS_W-1:0]  n_x   [0:3][0:2];
    logic signed [CRS_W-1:0]  r_x   [0:3][0:2];
    logic signed [CRS_W-1:0]  r_n   [ST_CRS+1:ST_SUM][0:2];
    logic                     r_dg  [ST_CRS+1:ST_DIVO];

    // First multiplier pass.
    logic signed [MUL_P_W-1:0] w_nn_p  [0:2];
    logic signed [MUL_P_W-1:0] w_sc_p  [0:2];
    logic signed [MUL_P_W-1:0] w_tri_p [0:2][0:2];

    // Dot product sums.
    logic signed [DOT_W-1:0]  n_nn;
    logic signed [DOT_W-1:0]  r_nn  [ST_SUM:ST_ABS];
    logic signed [SC_W-1:0]   n_sc;
    logic signed [SC_W-1:0]   r_sc;
    logic                     n_in;
    logic                     r_in  [ST_SUM:ST_DIVO];

    // Second multiplier pass and rounding operands.
    logic signed [MUL_P_W-1:0]     w_np [0:2];
    logic [NUM_W-1:0]              n_mag [0:2];
    logic [NUM_W-1:0]              r_mag [0:2];
    logic [2:0]                    n_ng;
    logic [2:0]                    r_ng  [ST_ABS:ST_DIVO];
    logic [LANES-1:0][XN_W-1:0]    n_xn;
    logic [LANES-1:0][XN_W-1:0]    r_xn;
    logic [DEN_W-1:0]              r_den;
    logic [LANES-1:0][QUO_W-1:0]   w_quo;

    // Result registers.
    t_result            n_fin;
    t_result            r_fin;
    t_result            r_out;
    t_result            r_skid;

    // The pipeline moves unless the skid register is occupied.
    assign w_adv      = !r_skid_vld;
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_skid_vld;

    assign w_pt = '{i_point_x,    i_point_y,    i_point_z};
    assign w_ca = '{i_corner_a_x, i_corner_a_y, i_corner_a_z};
    assign w_cb = '{i_corner_b_x, i_corner_b_y, i_corner_b_z};
    assign w_cc = '{i_corner_c_x, i_corner_c_y, i_corner_c_z};

    // Edge and point differences. Cross 0 is the normal (B-A)x(C-A); crosses
    // 1 to 3 are (B-P)x(C-P), (C-P)x(A-P) and (A-P)x(B-P).
    always_comb begin
        logic signed [DIFF_W-1:0] v_da, v_db, v_dc;
        for (int i = 0; i < 3; i++) begin
            v_da       = DIFF_W'(w_ca[i]) - DIFF_W'(w_pt[i]);
            v_db       = DIFF_W'(w_cb[i]) - DIFF_W'(w_pt[i]);
            v_dc       = DIFF_W'(w_cc[i]) - DIFF_W'(w_pt[i]);
            n_xa[0][i] = DIFF_W'(w_cb[i]) - DIFF_W'(w_ca[i]);
            n_xb[0][i] = DIFF_W'(w_cc[i]) - DIFF_W'(w_ca[i]);
            n_xa[1][i] = v_db;
            n_xb[1][i] = v_dc;
            n_xa[2][i] = v_dc;
            n_xb[2][i] = v_da;
            n_xa[3][i] = v_da;
            n_xb[3][i] = v_db;
            n_av[i]    = -v_da;
        end
    end

    // Cross product terms, then components.
    always_comb begin
        for (int x = 0; x < 4; x++) begin
            for (int c = 0; c < 3; c++) begin
                n_xp[x][2*c]   = PROD_W'(r_xa[x][IDX1[c]]) * PROD_W'(r_xb[x][IDX2[c]]);
                n_xp[x][2*c+1] = PROD_W'(r_xa[x][IDX2[c]]) * PROD_W'(r_xb[x][IDX1[c]]);
                n_x[x][c]      = CRS_W'(r_xp[x][2*c]) - CRS_W'(r_xp[x][2*c+1]);
            end
        end
    end

    // First multiplier pass: N.N, (P-A).N and the three inside tests.
    for (genvar gi = 0; gi < 3; gi++) begin : g_mul1
        ptp_mul u_nn (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (MUL_A_W'(r_x[0][gi])),
            .i_b   (MUL_B_W'(r_x[0][gi])),
            .o_p   (w_nn_p[gi])
        );
        ptp_mul u_sc (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (MUL_A_W'(r_x[0][gi])),
            .i_b   (MUL_B_W'(r_av[ST_CRS][gi])),
            .o_p   (w_sc_p[gi])
        );
        for (genvar gk = 0; gk < 3; gk++) begin : g_tri
            ptp_mul u_tri (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_a   (MUL_A_W'(r_x[gk+1][gi])),
                .i_b   (MUL_B_W'(r_x[0][gi])),
                .o_p   (w_tri_p[gk][gi])
            );
        end
    end

    // Dot product sums and the sign test of the three weights.
    always_comb begin
        logic signed [DOT_W-1:0] v_t;
        n_nn = DOT_W'(w_nn_p[0]) + DOT_W'(w_nn_p[1]) + DOT_W'(w_nn_p[2]);
        n_sc = SC_W'(w_sc_p[0]) + SC_W'(w_sc_p[1]) + SC_W'(w_sc_p[2]);
        n_in = 1'b1;
        for (int k = 0; k < 3; k++) begin
            v_t = DOT_W'(w_tri_p[k][0]) + DOT_W'(w_tri_p[k][1]) + DOT_W'(w_tri_p[k][2]);
            if (v_t[DOT_W-1]) begin
                n_in = 1'b0;
            end
        end
    end

    // Second multiplier pass: projection numerators sc * N_i.
    for (genvar gi = 0; gi < 3; gi++) begin : g_mul2
        ptp_mul u_np (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (MUL_A_W'(r_sc)),
            .i_b   (MUL_B_W'(r_n[ST_SUM][gi])),
            .o_p   (w_np[gi])
        );
    end

    // Sign and magnitude of each numerator, then the rounding numerator.
    always_comb begin
        logic signed [NUM_W-1:0] v_num;
        for (int i = 0; i < 3; i++) begin
            v_num    = NUM_W'(w_np[i]);
            n_ng[i]  = v_num[NUM_W-1];
            n_mag[i] = v_num[NUM_W-1] ? NUM_W'(-v_num) : v_num;
            n_xn[i]  = {r_mag[i], 1'b0} + XN_W'(r_nn[ST_ABS]);
        end
    end

    ptp_div u_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_den (r_den),
        .i_num (r_xn),
        .o_quo (w_quo)
    );

    // Apply the signed offset and saturate; a degenerate triangle passes the
    // point through.
    always_comb begin
        logic signed [PSUM_W-1:0] v_off;
        logic signed [PSUM_W-1:0] v_sum;
        logic [PSUM_W-COORD_BITS:0] v_hi;
        for (int i = 0; i < 3; i++) begin
            v_off = $signed({2'b00, w_quo[i]});
            if (r_ng[ST_DIVO][i]) begin
                v_off = -v_off;
            end
            v_sum = PSUM_W'(r_p[ST_DIVO][i]) - v_off;
            v_hi  = v_sum[PSUM_W-1:COORD_BITS-1];
            if (r_dg[ST_DIVO]) begin
                n_fin.proj[i] = r_p[ST_DIVO][i];
            end else if (v_hi == '0 || v_hi == '1) begin
                n_fin.proj[i] = v_sum[COORD_BITS-1:0];
            end else begin
                n_fin.proj[i] = v_sum[PSUM_W-1] ? SAT_MIN : SAT_MAX;
            end
        end
        n_fin.in_tri = r_in[ST_DIVO] && !r_dg[ST_DIVO];
        n_fin.degen  = r_dg[ST_DIVO];
    end

    // Pipeline data registers.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xa        <= n_xa;
            r_xb        <= n_xb;
            r_av[ST_DIF] <= n_av;
            r_p[ST_DIF]  <= w_pt;
            for (int s = ST_DIF + 1; s <= ST_CRS; s++) begin
                r_av[s] <= r_av[s-1];
            end
            for (int s = ST_DIF + 1; s <= ST_DIVO; s++) begin
                r_p[s] <= r_p[s-1];
            end
            r_xp <= n_xp;
            r_x  <= n_x;
            r_n[ST_CRS+1]  <= r_x[0];
            r_dg[ST_CRS+1] <= (r_x[0][0] == '0) && (r_x[0][1] == '0) && (r_x[0][2] == '0);
            for (int s = ST_CRS + 2; s <= ST_SUM; s++) begin
                r_n[s] <= r_n[s-1];
            end
            for (int s = ST_CRS + 2; s <= ST_DIVO; s++) begin
                r_dg[s] <= r_dg[s-1];
            end
            r_nn[ST_SUM] <= n_nn;
            r_sc         <= n_sc;
            r_in[ST_SUM] <= n_in;
            for (int s = ST_SUM + 1; s <= ST_ABS; s++) begin
                r_nn[s] <= r_nn[s-1];
            end
            for (int s = ST_SUM + 1; s <= ST_DIVO; s++) begin
                r_in[s] <= r_in[s-1];
            end
            r_mag        <= n_mag;
            r_ng[ST_ABS] <= n_ng;
            for (int s = ST_ABS + 1; s <= ST_DIVO; s++) begin
                r_ng[s] <= r_ng[s-1];
            end
            r_xn  <= n_xn;
            r_den <= {r_nn[ST_ABS][DOT_W-1:0], 1'b0};
            r_fin <= n_fin;
        end
    end

    // Output register and skid register payload.
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_vld ? r_skid : r_fin;
        end else if (w_adv) begin
            r_skid <= r_fin;
        end
    end

    // Valid bits of the pipeline and the output side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[ST_FIN-1:1], i_in_valid};
            end
            if (w_out_free) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld  <= r_vld[ST_FIN];
                end
            end else if (w_adv && r_vld[ST_FIN]) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_proj_x     = r_out.proj[0];
    assign o_proj_y     = r_out.proj[1];
    assign o_proj_z     = r_out.proj[2];
    assign o_inside_res = r_out.in_tri;
    assign o_degenerate = r_out.degen;

    // The skid register only fills behind an occupied output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register holds a result while the output is empty");

    // The skid register fills only when the output was stalled.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && i_out_stall))
        else $error("skid register filled without an output stall");

    // A skid result moves to the output as soon as the output drains.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_out_stall) |=> (r_out_vld && !r_skid_vld))
        else $error("skid result not forwarded after the output drained");

    // A degenerate triangle never reports inside.
    a_degen_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_inside_res && o_degenerate))
        else $error("degenerate result flagged as inside");

endmodule
